/* rtl/core/pnc_pkg.sv */
// shared types and constants for the perfect number check
package pnc_pkg;

    // width of the reported divisor sum field
    localparam int SUM_BITS = 18;

    // largest value the divisor sum field can carry
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_FINISH
    } t_state;

endpackage

/* rtl/core/perfect_number_check.sv */
// perfect number check: aliquot sum by trial division through a shared divider
//
//  channel   ports                               handshake
//  -------   ---------------------------------   ---------------------------
//  command   start, i_number                     taken when start & !busy
//  result    o_valid, o_is_perfect,              one-cycle strobe, no stall
//            o_divisor_sum
//
// trial divisors run from 2 upward, each one divided into the number by the
// shared restoring divider; the pass ends at the first divisor whose quotient
// falls below it, and 0 or 1 go straight to the result with no division.
// busy stays high until the result strobe; reset is synchronous and leaves
// the block idle. the receiver cannot stall the result.
module perfect_number_check #(
    parameter int WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [WIDTH-1:0]             i_number,
    output logic                         busy,
    output logic                         o_valid,
    output logic                         o_is_perfect,
    output logic [pnc_pkg::SUM_BITS-1:0] o_divisor_sum
);

    // exact aliquot sum stays below 7 * number for numbers up to 32 bits
    localparam int SUM_W = WIDTH + 3;
    localparam int EXT_W = (SUM_W > pnc_pkg::SUM_BITS) ? SUM_W : pnc_pkg::SUM_BITS;

    pnc_pkg::t_state r_state;
    pnc_pkg::t_state n_state;

    logic [WIDTH-1:0] r_num;
    logic [WIDTH-1:0] n_num;
    logic [WIDTH-1:0] r_dvs;
    logic [WIDTH-1:0] n_dvs;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;

    logic             w_accept;
    logic             w_div_start;
    logic             w_div_done;
    logic [WIDTH-1:0] w_quo;
    logic [WIDTH-1:0] w_rem;
    logic             w_last;
    logic [EXT_W-1:0] w_sum_ext;

    assign w_accept = start && (r_state == pnc_pkg::S_IDLE);
    // quotient below the divisor means divisor squared exceeds the number
    assign w_last   = (w_quo < r_dvs);

    // shared divider
    pnc_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_num),
        .i_divisor   (r_dvs),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pnc_pkg::S_IDLE: begin
                if (start) begin
                    n_state = (i_number < WIDTH'(2)) ? pnc_pkg::S_FINISH : pnc_pkg::S_ISSUE;
                end
            end
            pnc_pkg::S_ISSUE: begin
                n_state = pnc_pkg::S_WAIT;
            end
            pnc_pkg::S_WAIT: begin
                if (w_div_done) begin
                    n_state = w_last ? pnc_pkg::S_FINISH : pnc_pkg::S_ISSUE;
                end
            end
            pnc_pkg::S_FINISH: begin
                n_state = pnc_pkg::S_IDLE;
            end
            default: begin
                n_state = pnc_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        busy        = 1'b1;
        o_valid     = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            pnc_pkg::S_IDLE:   busy        = 1'b0;
            pnc_pkg::S_ISSUE:  w_div_start = 1'b1;
            pnc_pkg::S_WAIT:   w_div_start = 1'b0;
            pnc_pkg::S_FINISH: o_valid     = 1'b1;
            default:           busy        = 1'b1;
        endcase
    end

    // number, trial divisor and running sum
    always_comb begin
        n_num = r_num;
        n_dvs = r_dvs;
        n_sum = r_sum;
        if (w_accept) begin
            n_num = i_number;
            n_dvs = WIDTH'(2);
            // one divides every number of two or more
            n_sum = (i_number < WIDTH'(2)) ? '0 : SUM_W'(1);
        end else if ((r_state == pnc_pkg::S_WAIT) && w_div_done && !w_last) begin
            n_dvs = r_dvs + 1'b1;
            if (w_rem == '0) begin
                if (w_quo == r_dvs) begin
                    n_sum = r_sum + SUM_W'(r_dvs);
                end else begin
                    n_sum = r_sum + SUM_W'(r_dvs) + SUM_W'(w_quo);
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pnc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_dvs <= n_dvs;
        r_sum <= n_sum;
    end

    // result fields, sum saturated to the output width, flag on the exact sum
    assign w_sum_ext     = EXT_W'(r_sum);
    assign o_divisor_sum = (w_sum_ext > EXT_W'(pnc_pkg::SUM_MAX)) ?
                           pnc_pkg::SUM_MAX : w_sum_ext[pnc_pkg::SUM_BITS-1:0];
    assign o_is_perfect  = (r_num != '0) && (r_sum == SUM_W'(r_num));

endmodule

/* rtl/core/pnc_div.sv */
// restoring divider, one quotient bit per cycle, shared by all trial divisors
module pnc_div #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic             r_busy;
    logic             n_busy;
    logic             r_done;
    logic             n_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] n_quo;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] r_dvs;
    logic [WIDTH-1:0] n_dvs;
    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_diff;
    logic             w_fits;

    // one shift, compare and subtract step
    assign w_shift = {r_rem, r_quo[WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_fits  = (w_shift >= {1'b0, r_dvs});

    // step control and datapath next values
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(WIDTH - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[WIDTH-2:0], w_fits};
            n_rem = w_fits ? w_diff[WIDTH-1:0] : w_shift[WIDTH-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
